// ===== rtl/spdif_block_align_parity_check_assert.svh =====
// Assertion macros used by the block checker.
`ifndef SPDIF_BLOCK_ALIGN_PARITY_CHECK_ASSERT_SVH
`define SPDIF_BLOCK_ALIGN_PARITY_CHECK_ASSERT_SVH

// Checked on aclk, suppressed while aresetn is low.
`define SBAPC_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("spdif block checker assertion failed");

// Checked on aclk, including reset cycles.
`define SBAPC_ASSERT_RST(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("spdif block checker reset assertion failed");

`endif

// ===== rtl/spdif_bapc_pkg.sv =====
// Package: types and constants for the S/PDIF block alignment and parity checker.
`timescale 1ns / 1ps

package spdif_bapc_pkg;

    localparam int BLOCK_LEN   = 384;
    localparam int POS_W       = $clog2(BLOCK_LEN + 1);
    localparam int LEN_W       = 9;
    localparam int ERR_W       = 9;
    localparam int STATUS_BITS = 32;
    localparam int STATUS_SPAN = 2 * STATUS_BITS;
    localparam int HOLD_W      = 2;

    localparam logic [3:0] PRE_B = 4'b1111;
    localparam logic [3:0] PRE_M = 4'b1011;
    localparam logic [3:0] PRE_W = 4'b0111;

    localparam logic [HOLD_W-1:0] HOLDOFF_BLOCKS = HOLD_W'(3);
    localparam logic [ERR_W-1:0]  ERR_MAX        = '1;

    typedef struct packed {
        logic [31:0] subframe_word;
        logic        block_end;
    } sbapc_in_t;

    typedef struct packed {
        logic             align_ok;
        logic             parity_failed;
        logic [31:0]      channel_status;
        logic [ERR_W-1:0] block_parity_errors;
        logic [31:0]      total_parity_errors;
        logic [LEN_W-1:0] next_block_length;
    } sbapc_out_t;

endpackage

// ===== rtl/spdif_bapc_in_reg.sv =====
// Input register stage: holds one sub-frame transaction until the core takes it.
`timescale 1ns / 1ps

module spdif_bapc_in_reg
    import spdif_bapc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  sbapc_in_t s_item,
    output logic      q_valid,
    input  logic      q_take,
    output sbapc_in_t q_item
);

    logic      valid_reg;
    logic      valid_next;
    sbapc_in_t item_reg;

    assign s_ready    = !valid_reg || q_take;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign q_valid = valid_reg;
    assign q_item  = item_reg;

endmodule

// ===== rtl/spdif_bapc_core.sv =====
// Block state, per-sub-frame checks and the result register.
`timescale 1ns / 1ps

module spdif_bapc_core
    import spdif_bapc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       q_valid,
    output logic       q_take,
    input  sbapc_in_t  q_item,
    output logic       m_valid,
    input  logic       m_ready,
    output sbapc_out_t m_result
);

    logic              deep_check_reg;
    logic [POS_W-1:0]  pos_reg,      pos_next;
    logic              aligned_reg,  aligned_next;
    logic              done_reg,     done_next;
    logic              early_reg,    early_next;
    logic [31:0]       status_reg,   status_next;
    logic [ERR_W-1:0]  berr_reg,     berr_next;
    logic [31:0]       terr_reg,     terr_next;
    logic [POS_W-1:0]  lastb_reg,    lastb_next;
    logic [HOLD_W-1:0] hold_reg,     hold_next;
    logic [POS_W-1:0]  xlen_reg,     xlen_next;
    logic              m_valid_reg,  m_valid_next;
    sbapc_out_t        result_reg,   result_next;

    logic [3:0] sync;
    logic       even;
    logic       in_span;
    logic       mismatch;
    logic       par_err;

    // Non-final sub-frames never need the output slot.
    assign q_take = q_valid && (!q_item.block_end || !m_valid_reg || m_ready);

    assign sync     = q_item.subframe_word[3:0];
    assign even     = !pos_reg[0];
    assign in_span  = pos_reg < POS_W'(BLOCK_LEN);
    assign par_err  = (^q_item.subframe_word[30:4]) != q_item.subframe_word[31];

    always_comb begin
        pos_next     = pos_reg;
        aligned_next = aligned_reg;
        done_next    = done_reg;
        early_next   = early_reg;
        status_next  = status_reg;
        berr_next    = berr_reg;
        terr_next    = terr_reg;
        lastb_next   = lastb_reg;
        hold_next    = hold_reg;
        xlen_next    = xlen_reg;
        result_next  = result_reg;
        mismatch     = 1'b0;

        if (q_take) begin
            if (!done_reg && in_span) begin
                if (sync == PRE_B) begin
                    aligned_next = (pos_reg == '0);
                    lastb_next   = pos_reg;
                end
                if (aligned_next) begin
                    mismatch = even ? (sync != PRE_B && sync != PRE_M) : (sync != PRE_W);
                    if (mismatch) begin
                        aligned_next = 1'b0;
                        done_next    = 1'b1;
                    end else if (!deep_check_reg) begin
                        early_next = 1'b1;
                        done_next  = 1'b1;
                    end else begin
                        if (even && ({1'b0, pos_reg} < (POS_W + 1)'(STATUS_SPAN))) begin
                            status_next[pos_reg[5:1]] = q_item.subframe_word[30];
                        end
                        if (par_err && berr_reg != ERR_MAX) begin
                            berr_next = berr_reg + ERR_W'(1);
                        end
                    end
                end
            end
            if (in_span) begin
                pos_next = pos_reg + POS_W'(1);
            end

            if (q_item.block_end) begin
                if (!early_next) begin
                    terr_next = terr_reg + 32'(berr_next);
                    if (aligned_next) begin
                        xlen_next = POS_W'(BLOCK_LEN);
                    end else if (lastb_next != '0 && hold_reg == '0) begin
                        xlen_next = lastb_next;
                        hold_next = HOLDOFF_BLOCKS;
                    end else begin
                        xlen_next = POS_W'(BLOCK_LEN);
                        if (hold_reg != '0) begin
                            hold_next = hold_reg - HOLD_W'(1);
                        end
                    end
                end
                result_next.align_ok            = aligned_next;
                result_next.parity_failed       = berr_next != '0;
                result_next.channel_status      = status_next;
                result_next.block_parity_errors = berr_next;
                result_next.total_parity_errors = terr_next;
                result_next.next_block_length   = LEN_W'(xlen_next);

                pos_next   = '0;
                done_next  = 1'b0;
                early_next = 1'b0;
                berr_next  = '0;
                lastb_next = '0;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (q_take && q_item.block_end) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deep_check_reg <= 1'b1;
            pos_reg        <= '0;
            aligned_reg    <= 1'b0;
            done_reg       <= 1'b0;
            early_reg      <= 1'b0;
            status_reg     <= '0;
            berr_reg       <= '0;
            terr_reg       <= '0;
            lastb_reg      <= '0;
            hold_reg       <= '0;
            xlen_reg       <= POS_W'(BLOCK_LEN);
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                deep_check_reg <= cfg_wdata;
            end
            pos_reg     <= pos_next;
            aligned_reg <= aligned_next;
            done_reg    <= done_next;
            early_reg   <= early_next;
            status_reg  <= status_next;
            berr_reg    <= berr_next;
            terr_reg    <= terr_next;
            lastb_reg   <= lastb_next;
            hold_reg    <= hold_next;
            xlen_reg    <= xlen_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        result_reg <= result_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_result = result_reg;

endmodule

// ===== rtl/spdif_block_align_parity_check.sv =====
// Top level: S/PDIF sub-frame block alignment and parity checker.
//
//   channel   dir  handshake          payload
//   s_        in   s_valid/s_ready    sbapc_in_t  (sub-frame word, block end)
//   m_        out  m_valid/m_ready    sbapc_out_t (one per block)
//   cfg_      in   cfg_we             cfg_wdata   (deep_check)
//
// One sub-frame per cycle when not stalled; a block's last sub-frame passes the
// input register, then loads the result register and raises m_valid.
// The only stall source is a final sub-frame meeting an unread result.
// aresetn is synchronous: deep_check returns to 1, next length to BLOCK_LEN.
`timescale 1ns / 1ps

module spdif_block_align_parity_check
    import spdif_bapc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  sbapc_in_t  s_item,
    output logic       m_valid,
    input  logic       m_ready,
    output sbapc_out_t m_result
);

    logic      q_valid;
    logic      q_take;
    sbapc_in_t q_item;

    spdif_bapc_in_reg u_in_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_valid (q_valid),
        .q_take  (q_take),
        .q_item  (q_item)
    );

    spdif_bapc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_take    (q_take),
        .q_item    (q_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result)
    );

endmodule

// ===== rtl/spdif_bapc_checker.sv =====
// Port-level assertions for the block checker, bound to the top level.
`timescale 1ns / 1ps
`include "spdif_block_align_parity_check_assert.svh"

module spdif_bapc_checker
    import spdif_bapc_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       cfg_we,
    input logic       cfg_wdata,
    input logic       s_valid,
    input logic       s_ready,
    input sbapc_in_t  s_item,
    input logic       m_valid,
    input logic       m_ready,
    input sbapc_out_t m_result
);

    `SBAPC_ASSERT(a_result_hold, m_valid && !m_ready |=> m_valid && $stable(m_result))
    `SBAPC_ASSERT(a_fail_flag, m_valid |-> m_result.parity_failed == (m_result.block_parity_errors != '0))
    `SBAPC_ASSERT(a_len_nonzero, m_valid |-> m_result.next_block_length != '0 && m_result.next_block_length <= LEN_W'(BLOCK_LEN))
    `SBAPC_ASSERT_RST(a_reset_idle, !aresetn |=> !m_valid && s_ready)

endmodule

bind spdif_block_align_parity_check spdif_bapc_checker u_sbapc_checker (.*);
